/* rtl/qs_pkg.sv */
// Shared constants, command/status types and datapath select codes for the quicksort engine.
package qs_pkg;

    // Default configuration
    localparam int MAX_ITEMS_DEF   = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // Element store write selection
    typedef enum logic [2:0] {
        WR_NONE,
        WR_IN,         // incoming transaction into store[count]
        WR_I_FROM_J,   // first half of a swap: store[i] = store[j]
        WR_J_FROM_I,   // second half of a swap: store[j] = old store[i]
        WR_LO_FROM_I,  // pivot placement: store[lo] = store[i]
        WR_I_PIVOT     // pivot placement: store[i] = pivot
    } wr_sel_t;

    // Range stack push selection
    typedef enum logic [1:0] {
        PUSH_NONE,
        PUSH_INIT,     // whole set (0, count-1)
        PUSH_LEFT,     // (lo, mid-1)
        PUSH_RIGHT     // (mid+1, hi)
    } push_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        wr_sel_t   wr_sel;
        push_sel_t push_sel;
        logic      pop;
        logic      ld_range;
        logic      ld_pivot;
        logic      i_inc;
        logic      j_dec;
        logic      out_start;
        logic      set_done;
    } qs_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic i_lt_j;
        logic j_ge_pivot;
        logic i_le_pivot;
        logic lo_lt_i;
        logic push_l_ok;
        logic push_r_ok;
        logic sp_zero;
        logic few_items;
        logic out_last;
    } qs_stat_t;

endpackage

/* rtl/qs_datapath.sv */
// Datapath: element store, range stack, scan indexes, pivot and compare logic.
module qs_datapath import qs_pkg::*; #(
    parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  qs_cmd_t                       cmd,
    output qs_stat_t                      stat,
    input  logic signed [VALUE_WIDTH-1:0] in_value,
    output logic signed [VALUE_WIDTH-1:0] rd_value,
    output logic                          dropped
);

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int ENT_W = 2 * IDX_W;

    // Memories
    logic signed [VALUE_WIDTH-1:0] store_mem [MAX_ITEMS];
    logic        [ENT_W-1:0]       stack_mem [MAX_ITEMS];

    // Control registers
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] sp_reg;
    logic             dropped_reg;

    // Index, pivot and read data registers
    logic [IDX_W-1:0]              lo_reg, hi_reg, i_reg, j_reg;
    logic signed [VALUE_WIDTH-1:0] pivot_reg;
    logic signed [VALUE_WIDTH-1:0] rd_i_reg, rd_j_reg;
    logic [ENT_W-1:0]              stk_rd_reg;

    logic             store_room;
    logic             stack_room;
    logic             push_en;
    logic [ENT_W-1:0] push_data;
    logic [CNT_W-1:0] cnt_m1;
    logic [IDX_W:0]   lo_p1, i_p1, i_ext, hi_ext;

    assign store_room = count_reg < CNT_W'(MAX_ITEMS);
    assign stack_room = sp_reg < CNT_W'(MAX_ITEMS);
    assign cnt_m1     = count_reg - CNT_W'(1);
    assign lo_p1      = {1'b0, lo_reg} + (IDX_W+1)'(1);
    assign i_p1       = {1'b0, i_reg} + (IDX_W+1)'(1);
    assign i_ext      = {1'b0, i_reg};
    assign hi_ext     = {1'b0, hi_reg};

    // Range stack entry to push
    always_comb begin
        case (cmd.push_sel)
            PUSH_INIT:  push_data = {{IDX_W{1'b0}}, cnt_m1[IDX_W-1:0]};
            PUSH_LEFT:  push_data = {lo_reg, i_reg - IDX_W'(1)};
            PUSH_RIGHT: push_data = {i_reg + IDX_W'(1), hi_reg};
            default:    push_data = '0;
        endcase
    end
    assign push_en = (cmd.push_sel != PUSH_NONE) && stack_room;

    // Element store: one write port, two registered read ports at i and j
    always_ff @(posedge aclk) begin
        case (cmd.wr_sel)
            WR_IN: begin
                if (store_room) begin
                    store_mem[count_reg[IDX_W-1:0]] <= in_value;
                end
            end
            WR_I_FROM_J:  store_mem[i_reg]  <= rd_j_reg;
            WR_J_FROM_I:  store_mem[j_reg]  <= rd_i_reg;
            WR_LO_FROM_I: store_mem[lo_reg] <= rd_i_reg;
            WR_I_PIVOT:   store_mem[i_reg]  <= pivot_reg;
            default: ;
        endcase
        rd_i_reg <= store_mem[i_reg];
        rd_j_reg <= store_mem[j_reg];
    end

    // Range stack memory; read port follows the stack pointer
    always_ff @(posedge aclk) begin
        if (push_en) begin
            stack_mem[sp_reg[IDX_W-1:0]] <= push_data;
        end
        stk_rd_reg <= stack_mem[sp_reg[IDX_W-1:0]];
    end

    // Element count, drop flag and stack pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            sp_reg      <= '0;
        end else begin
            if (cmd.set_done) begin
                count_reg   <= '0;
                dropped_reg <= 1'b0;
            end else if (cmd.wr_sel == WR_IN) begin
                if (store_room) begin
                    count_reg <= count_reg + CNT_W'(1);
                end else begin
                    dropped_reg <= 1'b1;
                end
            end
            if (cmd.set_done) begin
                sp_reg <= '0;
            end else if (push_en) begin
                sp_reg <= sp_reg + CNT_W'(1);
            end else if (cmd.pop) begin
                sp_reg <= sp_reg - CNT_W'(1);
            end
        end
    end

    // Range bounds, scan indexes and pivot
    always_ff @(posedge aclk) begin
        if (cmd.ld_range) begin
            lo_reg <= stk_rd_reg[ENT_W-1:IDX_W];
            hi_reg <= stk_rd_reg[IDX_W-1:0];
            i_reg  <= stk_rd_reg[ENT_W-1:IDX_W];
            j_reg  <= stk_rd_reg[IDX_W-1:0];
        end else begin
            if (cmd.out_start) begin
                i_reg <= '0;
            end else if (cmd.i_inc) begin
                i_reg <= i_reg + IDX_W'(1);
            end
            if (cmd.j_dec) begin
                j_reg <= j_reg - IDX_W'(1);
            end
        end
        if (cmd.ld_pivot) begin
            pivot_reg <= rd_i_reg;
        end
    end

    // Status to the controller
    assign stat.i_lt_j     = i_reg < j_reg;
    assign stat.j_ge_pivot = rd_j_reg >= pivot_reg;
    assign stat.i_le_pivot = rd_i_reg <= pivot_reg;
    assign stat.lo_lt_i    = lo_reg < i_reg;
    assign stat.push_l_ok  = lo_p1 < i_ext;
    assign stat.push_r_ok  = i_p1 < hi_ext;
    assign stat.sp_zero    = sp_reg == '0;
    assign stat.few_items  = count_reg < CNT_W'(2);
    assign stat.out_last   = i_p1 == (IDX_W+1)'(count_reg);

    assign rd_value = rd_i_reg;
    assign dropped  = dropped_reg;

endmodule

/* rtl/qs_ctrl.sv */
// Controller: load, partition, stack and emit sequencing for the quicksort engine.
module qs_ctrl import qs_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_last,
    input  logic     m_ready,
    input  qs_stat_t stat,
    output qs_cmd_t  cmd,
    output logic     s_ready,
    output logic     m_valid
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SORT_INIT,
        ST_POP,
        ST_POP_RD,
        ST_LOAD,
        ST_PIV_RD,
        ST_PIV,
        ST_R_RD,
        ST_R_CMP,
        ST_L_RD,
        ST_L_CMP,
        ST_SW1,
        ST_SW2,
        ST_FIN_RD,
        ST_FIN1,
        ST_FIN2,
        ST_PUSH_L,
        ST_PUSH_R,
        ST_OUT_START,
        ST_OUT_RD,
        ST_OUT_SHOW
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, m_valid_reg;

    // Next state and datapath commands
    always_comb begin
        state_next = state_reg;
        cmd        = '{wr_sel: WR_NONE, push_sel: PUSH_NONE, default: 1'b0};
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.wr_sel = WR_IN;
                    if (s_last) state_next = ST_SORT_INIT;
                end
            end
            ST_SORT_INIT: begin
                if (stat.few_items) begin
                    state_next = ST_OUT_START;
                end else begin
                    cmd.push_sel = PUSH_INIT;
                    state_next   = ST_POP;
                end
            end
            ST_POP: begin
                if (stat.sp_zero) begin
                    state_next = ST_OUT_START;
                end else begin
                    cmd.pop    = 1'b1;
                    state_next = ST_POP_RD;
                end
            end
            ST_POP_RD: state_next = ST_LOAD;
            ST_LOAD: begin
                cmd.ld_range = 1'b1;
                state_next   = ST_PIV_RD;
            end
            ST_PIV_RD: state_next = ST_PIV;
            ST_PIV: begin
                cmd.ld_pivot = 1'b1;
                state_next   = ST_R_RD;
            end
            // Right scan: step j down past elements not below the pivot
            ST_R_RD: state_next = ST_R_CMP;
            ST_R_CMP: begin
                if (!stat.i_lt_j) begin
                    state_next = ST_FIN_RD;
                end else if (stat.j_ge_pivot) begin
                    cmd.j_dec  = 1'b1;
                    state_next = ST_R_RD;
                end else begin
                    state_next = ST_L_RD;
                end
            end
            // Left scan: step i up past elements not above the pivot
            ST_L_RD: state_next = ST_L_CMP;
            ST_L_CMP: begin
                if (!stat.i_lt_j) begin
                    state_next = ST_FIN_RD;
                end else if (stat.i_le_pivot) begin
                    cmd.i_inc  = 1'b1;
                    state_next = ST_L_RD;
                end else begin
                    state_next = ST_SW1;
                end
            end
            ST_SW1: begin
                cmd.wr_sel = WR_I_FROM_J;
                state_next = ST_SW2;
            end
            ST_SW2: begin
                cmd.wr_sel = WR_J_FROM_I;
                state_next = ST_R_RD;
            end
            // Move the pivot to its final place
            ST_FIN_RD: state_next = ST_FIN1;
            ST_FIN1: begin
                if (stat.lo_lt_i) begin
                    cmd.wr_sel = WR_LO_FROM_I;
                    state_next = ST_FIN2;
                end else begin
                    state_next = ST_PUSH_L;
                end
            end
            ST_FIN2: begin
                cmd.wr_sel = WR_I_PIVOT;
                state_next = ST_PUSH_L;
            end
            ST_PUSH_L: begin
                if (stat.push_l_ok) cmd.push_sel = PUSH_LEFT;
                state_next = ST_PUSH_R;
            end
            ST_PUSH_R: begin
                if (stat.push_r_ok) cmd.push_sel = PUSH_RIGHT;
                state_next = ST_POP;
            end
            // Emit sorted elements
            ST_OUT_START: begin
                cmd.out_start = 1'b1;
                state_next    = ST_OUT_RD;
            end
            ST_OUT_RD: state_next = ST_OUT_SHOW;
            ST_OUT_SHOW: begin
                if (m_ready) begin
                    if (stat.out_last) begin
                        cmd.set_done = 1'b1;
                        state_next   = ST_IDLE;
                    end else begin
                        cmd.i_inc  = 1'b1;
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State and registered handshake outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= state_next == ST_IDLE;
            m_valid_reg <= state_next == ST_OUT_SHOW;
        end
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

endmodule

/* rtl/quicksort_engine.sv */
// Top level of the quicksort engine: controller, datapath and port assertions.
//
// The engine takes one signed value per input transaction, one per cycle, into a
// MAX_ITEMS-entry store until a transaction with s_last arrives; values beyond
// capacity are dropped and m_overflow is set on every result of that set. It then
// sorts in place by iterative quicksort (leftmost pivot, two-ended scan) with
// pending ranges on a MAX_ITEMS-deep stack, and streams the sorted set out with
// m_last_res on the final element. s_ready is low from the last input until the
// last result is taken. Cost is set by the element store's registered read
// ports: each scan step passes through a read state and a compare state, each
// swap writes its two halves in turn, each partition adds states to pop the
// range, load the pivot and place it, and each result passes through a read
// state and a show state.
module quicksort_engine import qs_pkg::*; #(
    parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [VALUE_WIDTH-1:0] s_value,
    input  logic                          s_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [VALUE_WIDTH-1:0] m_value_res,
    output logic                          m_last_res,
    output logic                          m_overflow
);

    qs_cmd_t  cmd;
    qs_stat_t stat;

    qs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_last),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd),
        .s_ready (s_ready),
        .m_valid (m_valid)
    );

    qs_datapath #(
        .MAX_ITEMS   (MAX_ITEMS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .in_value (s_value),
        .rd_value (m_value_res),
        .dropped  (m_overflow)
    );

    assign m_last_res = stat.out_last;

    // Loading and emitting never overlap
    assert property (@(posedge aclk) disable iff (!aresetn) !(m_valid && s_ready))
        else $error("input and output channels active together");

    // A last input transaction closes the input channel
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last) |=> !s_ready)
        else $error("input still open after last transaction");

    // Taking the last result reopens the input channel
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_res) |=> (s_ready && !m_valid))
        else $error("engine did not return to loading after last result");

    // The stack is empty whenever a new set is loaded
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> stat.sp_zero)
        else $error("range stack not empty while loading");

endmodule
